// ----- rtl/esc_pkg.sv -----
// shared types and constants of the ejection sequence controller
`default_nettype none
package esc_pkg;

    localparam int unsigned LEVEL_W  = 11;
    localparam int unsigned RISK_W   = 10;
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned NUM_OUT  = 7;
    localparam int unsigned CIDX_W   = 3;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] REG_TRIGGER_LEVEL = 3'd0;
    localparam logic [CIDX_W-1:0] REG_ALARM_LEVEL   = 3'd1;
    localparam logic [CIDX_W-1:0] REG_TICKS_PER_SEC = 3'd2;
    localparam logic [CIDX_W-1:0] REG_ALARM_HOLD    = 3'd3;
    localparam logic [CIDX_W-1:0] REG_EJECT_SECOND  = 3'd4;
    localparam logic [CIDX_W-1:0] REG_CHUTE_SECOND  = 3'd5;

    // reset values of the configuration registers
    localparam logic [LEVEL_W-1:0] RST_TRIGGER_LEVEL = 11'd819;
    localparam logic [LEVEL_W-1:0] RST_ALARM_LEVEL   = 11'd512;
    localparam logic [COUNT_W-1:0] RST_TICKS_PER_SEC = 8'd20;
    localparam logic [COUNT_W-1:0] RST_ALARM_HOLD    = 8'd10;
    localparam logic [COUNT_W-1:0] RST_EJECT_SECOND  = 8'd5;
    localparam logic [COUNT_W-1:0] RST_CHUTE_SECOND  = 8'd8;

    // bit positions in the output latch vector
    localparam int unsigned OUT_CANOPY = 0;
    localparam int unsigned OUT_SEAT   = 1;
    localparam int unsigned OUT_MASK   = 2;
    localparam int unsigned OUT_ALARM  = 3;
    localparam int unsigned OUT_PILOT  = 4;
    localparam int unsigned OUT_EJECT  = 5;
    localparam int unsigned OUT_STRAP  = 6;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic [LEVEL_W-1:0] trigger_level;
        logic [LEVEL_W-1:0] alarm_level;
        logic [COUNT_W-1:0] ticks_per_second;
        logic [COUNT_W-1:0] alarm_hold_seconds;
        logic [COUNT_W-1:0] eject_second;
        logic [COUNT_W-1:0] chute_second;
    } cfg_t;

    typedef struct packed {
        logic              tick;
        logic              ring_pulled;
        logic              breath_detected;
        logic              restart;
        logic [RISK_W-1:0] risk_sample;
    } item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] tick_prescaler;
        logic [COUNT_W-1:0] sequence_seconds;
        logic               second_pending;
        logic               sequence_active;
        logic               alarm_active;
        logic [COUNT_W-1:0] alarm_seconds;
        logic               breath_watch;
        logic [NUM_OUT-1:0] output_latches;
    } state_t;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v == COUNT_MAX) ? COUNT_MAX : v + 1'b1;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/esc_cfg_regs.sv -----
// configuration register file of the ejection sequence controller
`default_nettype none
module esc_cfg_regs (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    input  wire logic [esc_pkg::CIDX_W-1:0]  cfg_index,
    input  wire logic [esc_pkg::LEVEL_W-1:0] cfg_data,
    output logic                             cfg_ready,
    output esc_pkg::cfg_t                    cfg
);
    import esc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_TRIGGER_LEVEL: cfg_next.trigger_level      = cfg_data;
                REG_ALARM_LEVEL:   cfg_next.alarm_level        = cfg_data;
                REG_TICKS_PER_SEC: cfg_next.ticks_per_second   = cfg_data[COUNT_W-1:0];
                REG_ALARM_HOLD:    cfg_next.alarm_hold_seconds = cfg_data[COUNT_W-1:0];
                REG_EJECT_SECOND:  cfg_next.eject_second       = cfg_data[COUNT_W-1:0];
                REG_CHUTE_SECOND:  cfg_next.chute_second       = cfg_data[COUNT_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_level      <= RST_TRIGGER_LEVEL;
            cfg_reg.alarm_level        <= RST_ALARM_LEVEL;
            cfg_reg.ticks_per_second   <= RST_TICKS_PER_SEC;
            cfg_reg.alarm_hold_seconds <= RST_ALARM_HOLD;
            cfg_reg.eject_second       <= RST_EJECT_SECOND;
            cfg_reg.chute_second       <= RST_CHUTE_SECOND;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/esc_step.sv -----
// next-state logic for one item of the ejection sequence controller
`default_nettype none
module esc_step (
    input  esc_pkg::item_t  item,
    input  esc_pkg::state_t cur,
    input  esc_pkg::cfg_t   cfg,
    output esc_pkg::state_t nxt
);
    import esc_pkg::*;

    logic risk_trigger;
    logic risk_alarm;

    assign risk_trigger = {1'b0, item.risk_sample} >= cfg.trigger_level;
    assign risk_alarm   = {1'b0, item.risk_sample} >= cfg.alarm_level;

    always_comb
    begin
        nxt = cur;

        // tick first: prescaler marks whole seconds
        if (item.tick)
        begin
            nxt.tick_prescaler = sat_inc(cur.tick_prescaler);
            if (nxt.tick_prescaler >= cfg.ticks_per_second)
            begin
                nxt.tick_prescaler = '0;
                if (cur.sequence_active)
                begin
                    nxt.sequence_seconds = sat_inc(cur.sequence_seconds);
                    nxt.second_pending   = 1'b1;
                end
                if (cur.alarm_active)
                begin
                    nxt.alarm_seconds = sat_inc(cur.alarm_seconds);
                end
            end
        end

        if (item.restart)
        begin
            nxt.output_latches   = '0;
            nxt.sequence_active  = 1'b0;
            nxt.breath_watch     = 1'b0;
            nxt.alarm_active     = 1'b0;
            nxt.sequence_seconds = '0;
            nxt.alarm_seconds    = '0;
        end
        else
        begin
            if (!nxt.sequence_active)
            begin
                if (item.ring_pulled || risk_trigger)
                begin
                    nxt.alarm_active                = 1'b0;
                    nxt.output_latches[OUT_ALARM]   = 1'b0;
                    nxt.sequence_active             = 1'b1;
                    nxt.output_latches[OUT_STRAP]   = 1'b1;
                    nxt.output_latches[OUT_CANOPY]  = 1'b1;
                    nxt.sequence_seconds            = '0;
                    nxt.tick_prescaler              = '0;
                    nxt.second_pending              = 1'b0;
                    nxt.breath_watch                = 1'b0;
                end
                else if (risk_alarm)
                begin
                    if (!nxt.alarm_active)
                    begin
                        nxt.alarm_active              = 1'b1;
                        nxt.output_latches[OUT_ALARM] = 1'b1;
                        nxt.alarm_seconds             = '0;
                        nxt.tick_prescaler            = '0;
                    end
                    else if (nxt.alarm_seconds >= cfg.alarm_hold_seconds)
                    begin
                        nxt.alarm_active               = 1'b0;
                        nxt.output_latches[OUT_ALARM]  = 1'b0;
                        nxt.sequence_active            = 1'b1;
                        nxt.output_latches[OUT_STRAP]  = 1'b1;
                        nxt.output_latches[OUT_CANOPY] = 1'b1;
                        nxt.sequence_seconds           = '0;
                    end
                end
                else if (nxt.alarm_active)
                begin
                    nxt.alarm_active              = 1'b0;
                    nxt.output_latches[OUT_ALARM] = 1'b0;
                    nxt.alarm_seconds             = '0;
                end
            end

            if (nxt.sequence_active && nxt.second_pending)
            begin
                nxt.second_pending = 1'b0;
                if (nxt.sequence_seconds == cfg.eject_second)
                begin
                    nxt.output_latches[OUT_EJECT] = 1'b1;
                end
                if (nxt.sequence_seconds == cfg.chute_second)
                begin
                    nxt.output_latches[OUT_SEAT] = 1'b1;
                    nxt.breath_watch             = 1'b1;
                end
            end

            if (nxt.breath_watch && item.breath_detected)
            begin
                nxt.output_latches[OUT_PILOT] = 1'b1;
                nxt.output_latches[OUT_MASK]  = 1'b1;
                nxt.output_latches[OUT_STRAP] = 1'b0;
                nxt.breath_watch              = 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/ejection_sequence_controller.sv -----
// top level of the ejection sequence controller: item register, state, result register
//
//  channel   direction  handshake                  payload
//  item      in         item_valid / item_stall    tick, ring_pulled, breath_detected,
//                                                  restart, risk_sample
//  result    out        result_valid / result_stall canopy_release ... strap_tighten
//  cfg       in         cfg_valid / cfg_ready      cfg_index, cfg_data
//
//  one item per cycle sustained while result_stall is low; an item's result passes
//  through the item register, then the result register, computed by the step logic
//  reset clears valid flags, sequence state and the configuration to its defaults
//  a stalled result holds in the result register while the item register still takes
//  one more item; the item channel stalls only when both are full; cfg_ready is always
//  high; the user must change registers only while the block is idle, unenforced
`default_nettype none
module ejection_sequence_controller (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // item channel
    input  wire logic                        item_valid,
    output logic                             item_stall,
    input  wire logic                        tick,
    input  wire logic                        ring_pulled,
    input  wire logic                        breath_detected,
    input  wire logic                        restart,
    input  wire logic [esc_pkg::RISK_W-1:0]  risk_sample,
    // result channel
    output logic                             result_valid,
    input  wire logic                        result_stall,
    output logic                             canopy_release,
    output logic                             seat_chute,
    output logic                             mask_release,
    output logic                             alarm_out,
    output logic                             pilot_chute,
    output logic                             eject_fire,
    output logic                             strap_tighten,
    // configuration write channel
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [esc_pkg::CIDX_W-1:0]  cfg_index,
    input  wire logic [esc_pkg::LEVEL_W-1:0] cfg_data
);
    import esc_pkg::*;

    cfg_t   cfg;

    // item register
    logic   item_valid_reg;
    logic   item_valid_next;
    item_t  item_reg;

    // sequence state and its next value
    state_t state_reg;
    state_t state_next;

    // result register
    logic               result_valid_reg;
    logic               result_valid_next;
    logic [NUM_OUT-1:0] result_reg;

    logic advance;      // item register moves into the result register
    logic item_take;    // item accepted this edge

    esc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready),
        .cfg       (cfg)
    );

    esc_step u_step (
        .item (item_reg),
        .cur  (state_reg),
        .cfg  (cfg),
        .nxt  (state_next)
    );

    // result slot is free when empty or being taken this cycle
    assign advance    = item_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall = item_valid_reg && !advance;
    assign item_take  = item_valid && !item_stall;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (item_take)
        begin
            item_valid_next = 1'b1;
        end
        else if (advance)
        begin
            item_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (advance)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            state_reg        <= '0;
        end
        else
        begin
            item_valid_reg   <= item_valid_next;
            result_valid_reg <= result_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            item_reg.tick            <= tick;
            item_reg.ring_pulled     <= ring_pulled;
            item_reg.breath_detected <= breath_detected;
            item_reg.restart         <= restart;
            item_reg.risk_sample     <= risk_sample;
        end
        if (advance)
        begin
            result_reg <= state_next.output_latches;
        end
    end

    assign result_valid   = result_valid_reg;
    assign canopy_release = result_reg[OUT_CANOPY];
    assign seat_chute     = result_reg[OUT_SEAT];
    assign mask_release   = result_reg[OUT_MASK];
    assign alarm_out      = result_reg[OUT_ALARM];
    assign pilot_chute    = result_reg[OUT_PILOT];
    assign eject_fire     = result_reg[OUT_EJECT];
    assign strap_tighten  = result_reg[OUT_STRAP];

`ifndef SYNTH
    // a processed restart leaves every drive off
    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item_reg.restart |=> result_reg == '0)
        else $error("restart did not clear the drives");

    // the alarm drive always tracks the alarm state
    a_alarm_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.output_latches[OUT_ALARM] == state_reg.alarm_active)
        else $error("alarm drive out of step with alarm state");

    // ejection and breath watch only inside an active sequence
    a_eject_in_seq: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.output_latches[OUT_EJECT] || state_reg.breath_watch
        |-> state_reg.sequence_active)
        else $error("ejection or breath watch outside a sequence");

    // state moves only when an item passes into the result register
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("state changed without an item");
`endif

endmodule
`default_nettype wire
